// File: rtl/core/ookrfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ookrfe_pkg;

  localparam int unsigned AddrW   = 22;
  localparam int unsigned RepeatW = 4;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned SegW    = 3;
  localparam int unsigned BitW    = 5;
  localparam int unsigned ChipW   = 3;

  localparam logic [AddrW-1:0]   AddrReset   = 22'h22ca1d;
  localparam logic [RepeatW-1:0] RepeatReset = 4'd10;

  // configuration register indexes
  localparam logic CfgAddress = 1'b0;
  localparam logic CfgRepeat  = 1'b1;

  // input function codes
  localparam logic FuncTick  = 1'b0;
  localparam logic FuncStart = 1'b1;

  localparam logic [21:0] StartPattern = 22'h3ffffe;
  localparam logic [15:0] OnesPattern  = 16'hffff;
  localparam logic [6:0]  Part3Pattern = 7'h3f;
  localparam logic [12:0] EndPattern   = 13'h000c;
  localparam logic [7:0]  ChipsOne     = 8'hfc;
  localparam logic [7:0]  ChipsZero    = 8'hc0;

  typedef enum logic [SegW-1:0] {
    SEG_START = 3'd0,
    SEG_ADDR  = 3'd1,
    SEG_CHAN  = 3'd2,
    SEG_ONES  = 3'd3,
    SEG_CMD   = 3'd4,
    SEG_PART3 = 3'd5,
    SEG_END   = 3'd6
  } seg_e;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic last_chip;
    logic rejected;
  } res_t;

  function automatic logic [BitW-1:0] seg_len(input seg_e seg);
    case (seg)
      SEG_START: seg_len = 5'd22;
      SEG_ADDR:  seg_len = 5'd22;
      SEG_CHAN:  seg_len = 5'd2;
      SEG_ONES:  seg_len = 5'd16;
      SEG_CMD:   seg_len = 5'd1;
      SEG_PART3: seg_len = 5'd7;
      SEG_END:   seg_len = 5'd13;
      default:   seg_len = 5'd1;
    endcase
  endfunction

  // channel index 0..3 goes on air as 11, 10, 01, 00 (lsb first)
  function automatic logic [ChanW-1:0] chan_code(input logic [ChanW-1:0] chan);
    case (chan)
      2'd0:    chan_code = 2'd3;
      2'd1:    chan_code = 2'd1;
      2'd2:    chan_code = 2'd2;
      default: chan_code = 2'd0;
    endcase
  endfunction

  function automatic logic [31:0] seg_data(input seg_e seg, input logic [AddrW-1:0] addr,
                                           input logic [ChanW-1:0] code, input logic cmd);
    case (seg)
      SEG_START: seg_data = {10'd0, StartPattern};
      SEG_ADDR:  seg_data = {10'd0, addr};
      SEG_CHAN:  seg_data = {30'd0, code};
      SEG_ONES:  seg_data = {16'd0, OnesPattern};
      SEG_CMD:   seg_data = {31'd0, cmd};
      SEG_PART3: seg_data = {25'd0, Part3Pattern};
      SEG_END:   seg_data = {19'd0, EndPattern};
      default:   seg_data = 32'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ook_remote_frame_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_stall_o   func_i, channel_i, switch_off_i
// out       source     out_valid_o / out_stall_i line_level_o, busy_res_o, last_chip_o, rejected_o
// cfg       sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one transaction in, one transaction out, one per cycle sustained while out_stall_i stays low
// frame state advances in the cycle a transaction is taken; the result is
// registered into the output register, or into the skid entry while the output is held
// an output register plus one skid entry absorbs one transaction under
// out_stall_i before in_stall_o rises; reset clears all control state, no clearing pass

module ook_remote_frame_encoder_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [ookrfe_pkg::AddrW-1:0]    cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic                            func_i,
  input  wire logic [ookrfe_pkg::ChanW-1:0]    channel_i,
  input  wire logic                            switch_off_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic                            line_level_o,
  output      logic                            busy_res_o,
  output      logic                            last_chip_o,
  output      logic                            rejected_o
);
  import ookrfe_pkg::*;

  logic [AddrW-1:0]   addr_q;
  logic [RepeatW-1:0] repeat_q;

  logic accept;
  logic out_free;
  res_t res_new;
  res_t out_q;
  res_t skid_q;
  logic out_valid_q;
  logic skid_valid_q;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= AddrReset;
      repeat_q <= RepeatReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAddress: addr_q   <= cfg_wdata_i;
        CfgRepeat:  repeat_q <= cfg_wdata_i[RepeatW-1:0];
        default:    ;
      endcase
    end
  end

  ookrfe_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .func_i       (func_i),
    .channel_i    (channel_i),
    .switch_off_i (switch_off_i),
    .address_i    (addr_q),
    .repeat_i     (repeat_q),
    .res_o        (res_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= accept;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (accept) begin
          skid_q <= res_new;
        end
      end else if (accept) begin
        out_q <= res_new;
      end
    end else if (accept) begin
      skid_q <= res_new;
    end
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign line_level_o = out_q.line_level;
  assign busy_res_o   = out_q.busy_res;
  assign last_chip_o  = out_q.last_chip;
  assign rejected_o   = out_q.rejected;

  // skid entry only fills behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid holds a transaction with output empty");

  // the skid stage only fills when the output was stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last_chip |-> !out_q.busy_res)
    else $error("last chip reported while still busy");

endmodule

`default_nettype wire

// File: rtl/core/ookrfe_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module ookrfe_seq (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic                         func_i,
  input  wire logic [ookrfe_pkg::ChanW-1:0] channel_i,
  input  wire logic                         switch_off_i,
  input  wire logic [ookrfe_pkg::AddrW-1:0] address_i,
  input  wire logic [ookrfe_pkg::RepeatW-1:0] repeat_i,
  output ookrfe_pkg::res_t                  res_o
);
  import ookrfe_pkg::*;

  seg_e               seg_q, seg_d;
  logic [BitW-1:0]    bit_q, bit_d;
  logic [ChipW-1:0]   chip_q, chip_d;
  logic [RepeatW-1:0] reps_q, reps_d;
  logic               sending_q, sending_d;
  logic [ChanW-1:0]   code_q, code_d;
  logic               cmd_q, cmd_d;

  logic [31:0]        data;
  logic               data_bit;
  logic [7:0]         chips;
  logic               raw;
  logic               bit_done;
  logic [BitW-1:0]    bit_inc;
  logic [RepeatW-1:0] reps_dec;

  always_comb begin
    seg_d     = seg_q;
    bit_d     = bit_q;
    chip_d    = chip_q;
    reps_d    = reps_q;
    sending_d = sending_q;
    code_d    = code_q;
    cmd_d     = cmd_q;
    res_o     = '0;

    data     = seg_data(seg_q, address_i, code_q, cmd_q);
    data_bit = data[bit_q];
    chips    = data_bit ? ChipsOne : ChipsZero;
    raw      = (seg_q == SEG_START) || (seg_q == SEG_END);
    bit_inc  = bit_q + 5'd1;
    reps_dec = reps_q - 4'd1;
    bit_done = 1'b0;

    if (func_i == FuncStart) begin
      if (sending_q) begin
        res_o.rejected = 1'b1;
      end else begin
        code_d    = chan_code(channel_i);
        cmd_d     = switch_off_i;
        reps_d    = (repeat_i == '0) ? RepeatW'(1) : repeat_i;
        seg_d     = SEG_START;
        bit_d     = '0;
        chip_d    = '0;
        sending_d = 1'b1;
      end
    end else if (sending_q) begin
      if (raw) begin
        res_o.line_level = data_bit;
        bit_done         = 1'b1;
      end else begin
        res_o.line_level = chips[chip_q];
        chip_d           = chip_q + 3'd1;
        bit_done         = (chip_q == 3'd7);
      end
      if (bit_done) begin
        chip_d = '0;
        bit_d  = bit_inc;
        if (bit_inc >= seg_len(seg_q)) begin
          bit_d = '0;
          if (seg_q == SEG_END) begin
            seg_d  = SEG_START;
            reps_d = reps_dec;
            if (reps_dec == '0) begin
              sending_d       = 1'b0;
              res_o.last_chip = 1'b1;
            end
          end else begin
            seg_d = seg_e'(seg_q + 3'd1);
          end
        end
      end
    end
    res_o.busy_res = sending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q     <= SEG_START;
      bit_q     <= '0;
      chip_q    <= '0;
      reps_q    <= '0;
      sending_q <= 1'b0;
      code_q    <= '0;
      cmd_q     <= 1'b0;
    end else if (step_i) begin
      seg_q     <= seg_d;
      bit_q     <= bit_d;
      chip_q    <= chip_d;
      reps_q    <= reps_d;
      sending_q <= sending_d;
      code_q    <= code_d;
      cmd_q     <= cmd_d;
    end
  end

  // frames left is nonzero exactly while a transmission runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) sending_q == (reps_q != '0))
    else $error("repeat counter out of step with sending flag");

  // start and end patterns go out one chip per bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_q == SEG_START || seg_q == SEG_END) |-> chip_q == '0)
    else $error("chip counter moved in a raw segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni) bit_q < seg_len(seg_q))
    else $error("bit index past segment end");

endmodule

`default_nettype wire

// File: tb/sv/ook_frame_checker.sv
`timescale 1ns / 1ps

module ook_frame_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [ookrfe_pkg::AddrW-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_stall_i,
  input  wire logic                         func_i,
  input  wire logic [ookrfe_pkg::ChanW-1:0] channel_i,
  input  wire logic                         switch_off_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_stall_i,
  input  wire logic                         line_level_i,
  input  wire logic                         busy_res_i,
  input  wire logic                         last_chip_i,
  input  wire logic                         rejected_i,
  output int                                fail_count_o,
  output int                                owed_o
);
  import ookrfe_pkg::*;

  // predicted transmitter state
  logic [AddrW-1:0]   addr_reg;
  logic [RepeatW-1:0] repeat_reg;
  seg_e               frame_seg;
  logic [BitW-1:0]    frame_bit;
  logic [ChipW-1:0]   frame_chip;
  logic [RepeatW-1:0] frames_left;
  logic               on_air;
  logic [ChanW-1:0]   chan_bits;
  logic               cmd_bit;

  res_t slot_q[$];
  int   fails;

  assign fail_count_o = fails;
  assign owed_o       = slot_q.size();

  function automatic res_t next_slot(input logic f, input logic [ChanW-1:0] ch,
                                     input logic off);
    res_t        res;
    logic [31:0] word;
    logic [7:0]  chips;
    logic [BitW-1:0] seg_bits;
    logic        raw;
    logic        bit_done;
    res = '0;
    if (f == FuncStart) begin
      if (on_air) begin
        res.rejected = 1'b1;
      end else begin
        // index 0..3 maps to 3,1,2,0: swap the two bits and invert
        chan_bits   = ~{ch[0], ch[1]};
        cmd_bit     = off;
        frames_left = (repeat_reg == '0) ? RepeatW'(1) : repeat_reg;
        frame_seg   = SEG_START;
        frame_bit   = '0;
        frame_chip  = '0;
        on_air      = 1'b1;
      end
    end else if (on_air) begin
      case (frame_seg)
        SEG_START: begin word = 32'(StartPattern); seg_bits = 5'd22; end
        SEG_ADDR:  begin word = 32'(addr_reg);     seg_bits = 5'd22; end
        SEG_CHAN:  begin word = 32'(chan_bits);    seg_bits = 5'd2;  end
        SEG_ONES:  begin word = 32'(OnesPattern);  seg_bits = 5'd16; end
        SEG_CMD:   begin word = 32'(cmd_bit);      seg_bits = 5'd1;  end
        SEG_PART3: begin word = 32'(Part3Pattern); seg_bits = 5'd7;  end
        SEG_END:   begin word = 32'(EndPattern);   seg_bits = 5'd13; end
        default:   begin word = '0;                seg_bits = 5'd1;  end
      endcase
      raw = (frame_seg == SEG_START) || (frame_seg >= SEG_END);
      if (raw) begin
        res.line_level = word[frame_bit];
        bit_done       = 1'b1;
      end else begin
        chips          = word[frame_bit] ? ChipsOne : ChipsZero;
        res.line_level = chips[frame_chip];
        frame_chip     = frame_chip + 1'b1;
        bit_done       = (frame_chip == '0);
      end
      if (bit_done) begin
        frame_chip = '0;
        frame_bit  = frame_bit + 1'b1;
        if (frame_bit >= seg_bits) begin
          frame_bit = '0;
          if (frame_seg >= SEG_END) begin
            frame_seg   = SEG_START;
            frames_left = frames_left - 1'b1;
            if (frames_left == '0) begin
              on_air        = 1'b0;
              res.last_chip = 1'b1;
            end
          end else begin
            frame_seg = seg_e'(frame_seg + 1'b1);
          end
        end
      end
    end
    res.busy_res = on_air;
    return res;
  endfunction

  task automatic check_field(input string what, input logic want, input logic got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      addr_reg    = AddrReset;
      repeat_reg  = RepeatReset;
      frame_seg   = SEG_START;
      frame_bit   = '0;
      frame_chip  = '0;
      frames_left = '0;
      on_air      = 1'b0;
      chan_bits   = '0;
      cmd_bit     = 1'b0;
      slot_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgAddress) begin
          addr_reg = cfg_wdata_i;
        end else begin
          repeat_reg = cfg_wdata_i[RepeatW-1:0];
        end
      end
      if (in_valid_i && !in_stall_i) begin
        slot_q.push_back(next_slot(func_i, channel_i, switch_off_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (slot_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected transaction, expected none, got %b%b%b%b", $time,
                   line_level_i, busy_res_i, last_chip_i, rejected_i);
        end else begin
          want = slot_q.pop_front();
          check_field("line_level", want.line_level, line_level_i);
          check_field("busy_res", want.busy_res, busy_res_i);
          check_field("last_chip", want.last_chip, last_chip_i);
          check_field("rejected", want.rejected, rejected_i);
        end
      end
    end
  end

endmodule

// File: tb/sv/ook_remote_frame_encoder_top_tb.sv
`timescale 1ns / 1ps

module ook_remote_frame_encoder_top_tb;
  import ookrfe_pkg::*;

  localparam int unsigned CycleLimit = 300000;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_we     = 1'b0;
  logic             cfg_idx    = CfgAddress;
  logic [AddrW-1:0] cfg_wdata  = '0;
  logic             in_valid   = 1'b0;
  logic             func       = FuncTick;
  logic [ChanW-1:0] channel    = '0;
  logic             switch_off = 1'b0;
  logic             out_stall  = 1'b0;

  logic in_stall, out_valid, line_level, busy_res, last_chip, rejected;
  int   fail_count, owed;

  int snd_idle_pct  = 0;
  int rcv_idle_pct  = 0;
  int hold_requests = 0;

  ook_remote_frame_encoder_top uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .channel_i    (channel),
    .switch_off_i (switch_off),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .line_level_o (line_level),
    .busy_res_o   (busy_res),
    .last_chip_o  (last_chip),
    .rejected_o   (rejected)
  );

  ook_frame_checker u_frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .channel_i    (channel),
    .switch_off_i (switch_off),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .line_level_i (line_level),
    .busy_res_i   (busy_res),
    .last_chip_i  (last_chip),
    .rejected_i   (rejected),
    .fail_count_o (fail_count),
    .owed_o       (owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver side: random stall, or a long hold-off when one is requested
  initial begin : rx_side
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  task automatic send_slot(input logic f, input logic [ChanW-1:0] ch, input logic off);
    @(negedge clk);
    // each idle cycle is drawn on its own so the idle share matches the percentage
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    channel    <= ch;
    switch_off <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly ticks; starts land both on idle and busy transmitter
  task automatic send_random(input int count);
    repeat (count) begin
      if ($urandom_range(39) == 0) begin
        send_slot(FuncStart, ChanW'($urandom), 1'($urandom));
      end else begin
        send_slot(FuncTick, ChanW'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [AddrW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic change_setting(input logic [AddrW-1:0] addr, input logic [RepeatW-1:0] reps,
                                input int snd_pct, input int rcv_pct);
    drain();
    write_reg(CfgAddress, addr);
    write_reg(CfgRepeat, AddrW'(reps));
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
  endtask

  initial begin : stimulus
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    change_setting(AddrW'($urandom), 4'd1, 30, 46);
    send_slot(FuncTick, 2'd3, 1'b1);
    send_slot(FuncStart, 2'd0, 1'b0);
    send_slot(FuncStart, 2'd3, 1'b1);
    send_slot(FuncStart, 2'd1, 1'b0);
    send_slot(FuncStart, 2'd2, 1'b1);
    repeat (12) send_slot(FuncTick, ChanW'($urandom), 1'($urandom));
    send_slot(FuncStart, 2'd1, 1'b1);
    send_random(430);

    // zero repeat count behaves as one frame
    change_setting(22'h3fffff, 4'd0, 46, 30);
    send_random(450);

    change_setting(22'h000000, 4'd2, 0, 0);
    hold_requests++;
    send_random(450);

    change_setting(AddrW'($urandom), 4'd15, 0, 0);
    send_random(200);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
